// File: design/wts_pkg.sv
// Shared constants, types and helper functions of the whitespace token splitter.
`default_nettype none
package wts_pkg;

    localparam int MAX_TOKENS     = 1024;
    localparam int MAX_TEXT_BYTES = 65536;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = $clog2(MAX_TEXT_BYTES + 1);
    localparam int CNT_W    = $clog2(MAX_TOKENS + 1);
    localparam int OFFSET_W = 16;
    localparam int LENGTH_W = 16;
    localparam int LINE_W   = 17;
    localparam int IDX_W    = 10;

    localparam int OFFSET_MAX = 65535;
    localparam int LINE_MAX   = 65536;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [3:0] {
        CLS_EMPTY  = 4'b0001,
        CLS_MINUS  = 4'b0010,
        CLS_DIGITS = 4'b0100,
        CLS_OTHER  = 4'b1000
    } t_class;

    typedef struct packed {
        logic                token_valid;
        logic                is_number;
        logic [OFFSET_W-1:0] start_offset;
        logic [LENGTH_W-1:0] token_length;
        logic [LINE_W-1:0]   line_number;
        logic [LINE_W-1:0]   column;
        logic [IDX_W-1:0]    token_index;
        logic                dropped;
        logic                end_of_text;
    } t_result;

    function automatic logic is_sep(input logic [BYTE_W-1:0] c);
        return c inside {CH_SPACE, CH_LF, CH_TAB, CH_CR};
    endfunction

    function automatic t_class next_class(input t_class cls, input logic [BYTE_W-1:0] c);
        logic digit;
        t_class nxt;
        digit = c inside {[CH_ZERO:CH_NINE]};
        case (cls)
            CLS_EMPTY: begin
                if (c == CH_MINUS) nxt = CLS_MINUS;
                else if (digit)    nxt = CLS_DIGITS;
                else               nxt = CLS_OTHER;
            end
            CLS_MINUS, CLS_DIGITS: begin
                nxt = digit ? CLS_DIGITS : CLS_OTHER;
            end
            default: begin
                nxt = CLS_OTHER;
            end
        endcase
        return nxt;
    endfunction

    // Advance a position counter, stopping at the text limit.
    function automatic logic [POS_W-1:0] inc_pos(input logic [POS_W-1:0] v);
        return (v == POS_W'(MAX_TEXT_BYTES)) ? v : v + POS_W'(1);
    endfunction

    function automatic logic [OFFSET_W-1:0] cap_offset(input logic [POS_W-1:0] v);
        return (32'(v) > 32'(OFFSET_MAX)) ? OFFSET_W'(OFFSET_MAX) : OFFSET_W'(v);
    endfunction

    // 1-based column from a start and a line start; start never lies before line start.
    function automatic logic [LINE_W-1:0] make_column(input logic [POS_W-1:0] start,
                                                      input logic [POS_W-1:0] lbeg);
        logic [31:0] col;
        col = 32'(start - lbeg) + 32'd1;
        return (col > 32'(LINE_MAX)) ? LINE_W'(LINE_MAX) : LINE_W'(col);
    endfunction

endpackage
`default_nettype wire

// File: design/wts_if.sv
// Handshake channels of the token splitter: text bytes in, token reports out.
`default_nettype none
interface wts_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface wts_token_if;
    logic        valid;
    logic        ready;
    logic        token_valid;
    logic        is_number;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [16:0] line_number;
    logic [16:0] column;
    logic [9:0]  token_index;
    logic        dropped;
    logic        end_of_text;

    modport source (output valid, output token_valid, output is_number,
                    output start_offset, output token_length, output line_number,
                    output column, output token_index, output dropped,
                    output end_of_text, input ready);
    modport sink   (input valid, input token_valid, input is_number,
                    input start_offset, input token_length, input line_number,
                    input column, input token_index, input dropped,
                    input end_of_text, output ready);
endinterface
`default_nettype wire

// File: design/wts_core.sv
// Token splitter state: counters, class tracking and formation of the report for each token and text end.
`default_nettype none
module wts_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [wts_pkg::BYTE_W-1:0] i_byte,
    output logic                  o_emit,
    output wts_pkg::t_result      o_result
);
    import wts_pkg::*;

    logic [POS_W-1:0]  r_position,    n_position;
    logic [POS_W-1:0]  r_token_begin, n_token_begin;
    logic [POS_W-1:0]  r_line_begin,  n_line_begin;
    logic [LINE_W-1:0] r_line_count,  n_line_count;
    logic [CNT_W-1:0]  r_stored,      n_stored;
    t_class            r_class,       n_class;

    logic             is_end;
    logic             sep;
    logic             pending;
    logic             keep;
    logic [POS_W-1:0] pos_inc;

    always_comb begin
        is_end  = (i_byte == CH_NUL);
        sep     = is_sep(i_byte);
        pending = (r_class != CLS_EMPTY);
        keep    = (r_stored < CNT_W'(MAX_TOKENS));
        pos_inc = inc_pos(r_position);
        o_emit  = is_end || (sep && pending);
    end

    always_comb begin
        o_result             = '0;
        o_result.line_number = r_line_count;
        o_result.end_of_text = is_end;
        if (pending) begin
            o_result.token_valid  = keep;
            o_result.is_number    = (r_class == CLS_DIGITS);
            o_result.start_offset = cap_offset(r_token_begin);
            o_result.token_length = cap_offset(r_position - r_token_begin);
            o_result.column       = make_column(r_token_begin, r_line_begin);
            o_result.token_index  = keep ? IDX_W'(r_stored) : '0;
            o_result.dropped      = !keep;
        end else begin
            o_result.start_offset = cap_offset(r_position);
            o_result.column       = make_column(r_position, r_line_begin);
        end
    end

    always_comb begin
        n_position    = r_position;
        n_token_begin = r_token_begin;
        n_line_begin  = r_line_begin;
        n_line_count  = r_line_count;
        n_stored      = r_stored;
        n_class       = r_class;
        if (i_step) begin
            if (is_end) begin
                // restart everything for the next text
                n_position    = '0;
                n_token_begin = '0;
                n_line_begin  = '0;
                n_line_count  = LINE_W'(1);
                n_stored      = '0;
                n_class       = CLS_EMPTY;
            end else if (sep) begin
                if (pending && keep) begin
                    n_stored = r_stored + CNT_W'(1);
                end
                n_class       = CLS_EMPTY;
                n_position    = pos_inc;
                n_token_begin = pos_inc;
                if (i_byte == CH_LF) begin
                    n_line_begin = pos_inc;
                    if (r_line_count != LINE_W'(LINE_MAX)) begin
                        n_line_count = r_line_count + LINE_W'(1);
                    end
                end
            end else begin
                n_class    = next_class(r_class, i_byte);
                n_position = pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position    <= '0;
            r_token_begin <= '0;
            r_line_begin  <= '0;
            r_line_count  <= LINE_W'(1);
            r_stored      <= '0;
            r_class       <= CLS_EMPTY;
        end else begin
            r_position    <= n_position;
            r_token_begin <= n_token_begin;
            r_line_begin  <= n_line_begin;
            r_line_count  <= n_line_count;
            r_stored      <= n_stored;
            r_class       <= n_class;
        end
    end

endmodule
`default_nettype wire

// File: design/wts_out_reg.sv
// Result register of the token splitter: holds one report until the sink takes it.
`default_nettype none
module wts_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wts_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_space,
    output logic             o_valid,
    output wts_pkg::t_result o_result
);
    import wts_pkg::*;

    logic    r_valid;
    t_result r_result;

    // free when empty or when the held word leaves this cycle
    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

// File: design/whitespace_token_splitter.sv
// Top level of the whitespace token splitter: input register, core and result register.
// A byte taken sits in the input register; when it advances, its report is loaded into
//   the result register, raising o_tok.valid.
// Throughput: one byte per cycle while reports find space; a stalled sink stops intake
//   once the result register is full and the held byte makes a report.
// Reset (synchronous, active low): empties both registers and restarts all counters.
`default_nettype none
module whitespace_token_splitter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wts_text_if.sink     i_text,
    wts_token_if.source  o_tok
);
    import wts_pkg::*;

    // Input register: one text byte waiting for the core.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    logic    emit;
    logic    space;
    logic    advance;
    t_result core_result;
    t_result out_result;

    // Advance the held byte when it makes no report, or when the result register is free.
    assign advance      = r_in_valid && (!emit || space);
    assign i_text.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    // Payload needs no reset; capture only when a byte is taken.
    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_byte <= i_text.text_byte;
        end
    end

    // Counters, class tracking and report formation.
    wts_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_result (core_result)
    );

    // Hold a report until the sink takes it.
    wts_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (core_result),
        .i_ready  (o_tok.ready),
        .o_space  (space),
        .o_valid  (o_tok.valid),
        .o_result (out_result)
    );

    // Drive the output channel from the result register.
    assign o_tok.token_valid  = out_result.token_valid;
    assign o_tok.is_number    = out_result.is_number;
    assign o_tok.start_offset = out_result.start_offset;
    assign o_tok.token_length = out_result.token_length;
    assign o_tok.line_number  = out_result.line_number;
    assign o_tok.column       = out_result.column;
    assign o_tok.token_index  = out_result.token_index;
    assign o_tok.dropped      = out_result.dropped;
    assign o_tok.end_of_text  = out_result.end_of_text;

    // A report leaving the core must appear on the output at the next edge.
    a_emit_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit) |=> o_tok.valid)
        else $error("report from core did not reach the result register");

    // An empty input register must always take a new byte.
    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_text.ready)
        else $error("input register empty but intake stalled");

    // A dropped token is never also a stored one, and carries index zero.
    a_drop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.dropped) |-> (!o_tok.token_valid && o_tok.token_index == '0))
        else $error("dropped token carries stored-token fields");

endmodule
`default_nettype wire

// File: dv/token_checker.sv
`timescale 1ns / 100ps
// Token report checker: follows the accepted text bytes, predicts each report and compares it.
module token_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wts_text_if   i_text,
    wts_token_if  i_tok,
    output int    o_pending,
    output int    o_fail_count
);
    import wts_pkg::*;

    // Tokeniser state of the text in progress
    logic [POS_W-1:0]  byte_pos;
    logic [POS_W-1:0]  tok_start;
    logic [POS_W-1:0]  line_head;
    logic [LINE_W-1:0] line_no;
    t_class            tok_class;
    logic [CNT_W-1:0]  stored_cnt;

    t_result           reports_due[$];
    t_result           want;

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [POS_W-1:0] advance_pos(input logic [POS_W-1:0] v);
        return (32'(v) < MAX_TEXT_BYTES) ? v + 1'b1 : v;
    endfunction

    function automatic void clear_text();
        byte_pos   = '0;
        tok_start  = '0;
        line_head  = '0;
        line_no    = LINE_W'(1);
        tok_class  = CLS_EMPTY;
        stored_cnt = '0;
    endfunction

    // Build the report of the pending token; count it if the table still has room.
    function automatic t_result token_report(input bit at_end);
        t_result     r;
        int unsigned len;
        int unsigned col;
        bit          keep;
        len  = (byte_pos >= tok_start) ? 32'(byte_pos) - 32'(tok_start) : 0;
        col  = (tok_start >= line_head) ? 32'(tok_start) - 32'(line_head) + 1 : 1;
        keep = (32'(stored_cnt) < MAX_TOKENS);
        r.token_valid  = keep;
        r.is_number    = (tok_class == CLS_DIGITS);
        r.start_offset = OFFSET_W'(clamp_to(32'(tok_start), OFFSET_MAX));
        r.token_length = LENGTH_W'(clamp_to(len, OFFSET_MAX));
        r.line_number  = LINE_W'(clamp_to(32'(line_no), LINE_MAX));
        r.column       = LINE_W'(clamp_to(col, LINE_MAX));
        r.token_index  = keep ? stored_cnt[IDX_W-1:0] : '0;
        r.dropped      = !keep;
        r.end_of_text  = at_end;
        if (keep) stored_cnt = stored_cnt + 1'b1;
        return r;
    endfunction

    task automatic tokenise_byte(input logic [BYTE_W-1:0] c);
        t_result     r;
        bit          is_digit;
        bit          is_blank;
        int unsigned col;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
        if (c == CH_NUL) begin
            if (tok_class != CLS_EMPTY) begin
                r = token_report(1'b1);
            end else begin
                col            = (byte_pos >= line_head) ?
                                 32'(byte_pos) - 32'(line_head) + 1 : 1;
                r              = '0;
                r.start_offset = OFFSET_W'(clamp_to(32'(byte_pos), OFFSET_MAX));
                r.line_number  = LINE_W'(clamp_to(32'(line_no), LINE_MAX));
                r.column       = LINE_W'(clamp_to(col, LINE_MAX));
                r.end_of_text  = 1'b1;
            end
            reports_due.push_back(r);
            clear_text();
        end else if (is_blank) begin
            if (tok_class != CLS_EMPTY) reports_due.push_back(token_report(1'b0));
            tok_class = CLS_EMPTY;
            byte_pos  = advance_pos(byte_pos);
            tok_start = byte_pos;
            if (c == CH_LF) begin
                line_head = byte_pos;
                if (32'(line_no) < LINE_MAX) line_no = line_no + 1'b1;
            end
        end else begin
            if (tok_class == CLS_EMPTY) begin
                if (c == CH_MINUS)  tok_class = CLS_MINUS;
                else if (is_digit)  tok_class = CLS_DIGITS;
                else                tok_class = CLS_OTHER;
            end else if (tok_class != CLS_OTHER) begin
                tok_class = is_digit ? CLS_DIGITS : CLS_OTHER;
            end
            byte_pos = advance_pos(byte_pos);
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_text();
            reports_due.delete();
        end else begin
            if (i_tok.valid && i_tok.ready) begin
                if (reports_due.size() == 0) begin
                    $error("token report word arrived with none expected");
                    o_fail_count++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("token_valid",  32'(want.token_valid),
                                32'(i_tok.token_valid));
                    check_field("is_number",    32'(want.is_number),
                                32'(i_tok.is_number));
                    check_field("start_offset", 32'(want.start_offset),
                                32'(i_tok.start_offset));
                    check_field("token_length", 32'(want.token_length),
                                32'(i_tok.token_length));
                    check_field("line_number",  32'(want.line_number),
                                32'(i_tok.line_number));
                    check_field("column",       32'(want.column),
                                32'(i_tok.column));
                    check_field("token_index",  32'(want.token_index),
                                32'(i_tok.token_index));
                    check_field("dropped",      32'(want.dropped),
                                32'(i_tok.dropped));
                    check_field("end_of_text",  32'(want.end_of_text),
                                32'(i_tok.end_of_text));
                end
            end
            if (i_text.valid && i_text.ready) tokenise_byte(i_text.text_byte);
        end
        o_pending = reports_due.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Bench top of the token splitter: clock, reset, text stimulus, report stalls and verdict.
module testbench;
    import wts_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;   // cycles with no word moving on either side
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off, fills the block
    localparam int PHASE_BYTES    = 60;     // minimum random text bytes per idling phase
    localparam int DRAIN_CYCLES   = 10;     // extra wait after the last expected report

    localparam logic [BYTE_W-1:0] CH_LOW_A = "a";
    localparam logic [BYTE_W-1:0] CH_LOW_Z = "z";
    localparam logic [BYTE_W-1:0] CH_LOW_X = "x";

    typedef enum int {
        TK_INT,
        TK_MINUS,
        TK_WORD,
        TK_INT_TAIL,
        TK_MINUS_TAIL,
        TK_JUNK
    } t_tok_kind;

    logic i_clk;
    logic i_rst_n;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_asked;
    int hold_done;
    int quiet_cycles;
    int bytes_sent;
    int pending;
    int fail_count;

    wts_text_if  text_ch();
    wts_token_if tok_ch();

    whitespace_token_splitter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_ch),
        .o_tok   (tok_ch)
    );

    token_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text       (text_ch),
        .i_tok        (tok_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Report side: stall at the phase's rate; on request, hold ready low for a long
    // stretch so that both internal registers fill and the text side backs up.
    initial begin
        tok_ch.ready = 1'b0;
        hold_done    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_done != hold_asked) begin
                tok_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = hold_asked;
            end else begin
                tok_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run if no word moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (text_ch.valid && text_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one text byte; call at a falling edge, returns at the falling edge after
    // acceptance. Valid stays high between back-to-back words.
    task automatic offer_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            text_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        do @(posedge i_clk); while (!text_ch.ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic offer_string(input string s);
        foreach (s[k]) offer_byte(s[k]);
    endtask

    function automatic logic [BYTE_W-1:0] pick_sep();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_digit();
        return CH_ZERO + BYTE_W'($urandom_range(9));
    endfunction

    // Any byte that can sit inside a token: neither zero nor a separator.
    function automatic logic [BYTE_W-1:0] pick_inner();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(1, 255));
        while (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)
            b = BYTE_W'($urandom_range(1, 255));
        return b;
    endfunction

    task automatic offer_random_token();
        t_tok_kind kind;
        int        len;
        kind = t_tok_kind'($urandom_range(TK_JUNK));
        len  = $urandom_range(1, 5);
        case (kind)
            TK_INT: begin
                if ($urandom_range(1)) offer_byte(CH_MINUS);
                repeat (len) offer_byte(pick_digit());
            end
            TK_MINUS: begin
                offer_byte(CH_MINUS);
            end
            TK_WORD: begin
                repeat (len) offer_byte(BYTE_W'($urandom_range(CH_LOW_A, CH_LOW_Z)));
            end
            TK_INT_TAIL: begin
                repeat (len) offer_byte(pick_digit());
                offer_byte(pick_inner());
            end
            TK_MINUS_TAIL: begin
                offer_byte(CH_MINUS);
                offer_byte(pick_inner());
            end
            default: begin
                repeat (len) offer_byte(pick_inner());
            end
        endcase
    endtask

    // One whole text: mostly tokens between separators, sometimes raw noise.
    task automatic offer_random_text();
        int n_tok;
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 12)) offer_byte(BYTE_W'($urandom_range(1, 255)));
        end else begin
            n_tok = $urandom_range(0, 6);
            if ($urandom_range(1)) offer_byte(pick_sep());
            for (int t = 0; t < n_tok; t++) begin
                offer_random_token();
                // the last token sometimes runs straight into the end byte
                if (t < n_tok - 1 || $urandom_range(1))
                    repeat ($urandom_range(1, 3)) offer_byte(pick_sep());
            end
        end
        offer_byte(CH_NUL);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int first;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first          = bytes_sent;
        while (bytes_sent - first < PHASE_BYTES) offer_random_text();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = CH_NUL;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_asked        = 0;
        bytes_sent        = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty text, separators only, each token class, byte extremes
        offer_byte(CH_NUL);
        offer_string(" \t\r\n");
        offer_byte(CH_NUL);
        offer_string("-09 -\ta-\r9x\n");
        offer_byte(8'hFF);
        offer_byte(CH_NUL);
        offer_string("7 ");
        offer_byte(CH_NUL);

        // Ask for the long hold-off while the text side keeps pushing words
        hold_asked++;

        // Overfill the token table: the last few tokens come back dropped
        for (int n = 0; n < MAX_TOKENS + 6; n++) begin
            offer_byte($urandom_range(1) ? pick_digit() : CH_LOW_X);
            offer_byte(pick_sep());
        end
        offer_string("-5");
        offer_byte(CH_NUL);

        // Random texts under each idling pattern
        run_phase(0, 0);
        run_phase(84, 0);
        run_phase(0, 84);
        run_phase(20, 20);

        text_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
